### hdl/bbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared constants, request and result types for the block bitmap allocator.
// ----------------------------------------------------------------------------
package bbm_pkg;

  // Map geometry
  localparam int MAX_SECTORS  = 8;
  localparam int SECTOR_BYTES = 512;
  localparam int WORD_BITS    = 64;

  localparam int SECTOR_BITS  = SECTOR_BYTES * 8;
  localparam int MAP_BITS     = MAX_SECTORS * SECTOR_BITS;
  localparam int MAP_WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int SECTOR_WORDS = (SECTOR_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int WORD_AW      = $clog2(MAP_WORDS);
  localparam int BIT_AW       = $clog2(WORD_BITS);
  localparam int LIMW_W       = $clog2(MAP_WORDS + 1);
  localparam int LIMB_W       = $clog2(MAP_BITS + 1);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int BLK_W   = 15;
  localparam int WIDX_W  = 9;
  localparam int DATA_W  = 64;
  localparam int SECT_W  = 4;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TEST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_USE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD = 3'd4;

  // Status codes
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_IGNORE = 1'b1;

  localparam logic [SECT_W-1:0] SECTORS_RESET = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block_index;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic             is_free;
    logic             found;
    logic [BLK_W-1:0] free_block;
    logic             status;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/block_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// Disk block bitmap held in one RAM word array: test, find first free,
// mark used, mark free and word load, one request in flight at a time.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in_      input      in_valid / in_stall      in_data  (in_item_t)
//  out_     output     out_valid / out_stall    out_data (out_item_t)
//  cfg_     input      cfg_wr_en                cfg_wr_data (map sectors)
//
//  Test and mark pass through ST_RD and ST_RESP; load and rejected requests
//  go from ST_IDLE to ST_RESP. Find walks the map RAM one word a cycle
//  through its single read port, over at most lim_words words (lim_words =
//  sectors * 64). After reset a clearing pass writes zero to all 512 map
//  words, one a cycle, with in_stall held high. The result sits in an
//  output register, so a stalled output only holds the next result back.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
  import bbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [SECT_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset RAM wipe
    ST_IDLE,    // waiting for a request
    ST_RD,      // word for test / mark is on the RAM output
    ST_SCAN,    // find: checking one word a cycle
    ST_ENC,     // find: locate lowest clear bit in the hit word
    ST_RESP     // result ready, waiting for the output register
  } state_t;

  state_t                 state_r, state_nxt;
  in_item_t               req_r, req_nxt;
  out_item_t              res_r, res_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_AW-1:0]     scan_r, scan_nxt;
  logic [WORD_AW-1:0]     clr_r, clr_nxt;
  logic [WORD_BITS-1:0]   hit_r, hit_nxt;
  logic [SECT_W-1:0]      sectors_r, sectors_nxt;

  // RAM port
  logic                   mem_we;
  logic [WORD_AW-1:0]     mem_waddr;
  logic [WORD_BITS-1:0]   mem_wdata;
  logic [WORD_AW-1:0]     mem_raddr;
  logic [WORD_BITS-1:0]   mem_rdata;

  // Configured map size
  logic [SECT_W-1:0]      sect_eff;
  logic [LIMB_W-1:0]      lim_bits;
  logic [LIMW_W-1:0]      lim_words;
  logic                   blk_ok;
  logic                   widx_ok;
  logic [WORD_AW-1:0]     in_word;
  logic [BIT_AW-1:0]      req_bit;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [WORD_BITS-1:0]   inv_word;
  logic [LIMW_W-1:0]      scan_next_w;

  // Lowest set bit of a non-zero word
  function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_AW'(i);
      end
    end
    return idx;
  endfunction

  bbm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sector counts above the maximum behave as the maximum
  assign sect_eff  = (sectors_r > SECT_W'(MAX_SECTORS)) ? SECT_W'(MAX_SECTORS) : sectors_r;
  assign lim_bits  = LIMB_W'(sect_eff) * LIMB_W'(SECTOR_BITS);
  assign lim_words = LIMW_W'(sect_eff) * LIMW_W'(SECTOR_WORDS);

  assign blk_ok    = LIMB_W'(in_data.block_index) < lim_bits;
  assign widx_ok   = LIMW_W'(in_data.word_index) < lim_words;
  assign in_word   = in_data.block_index[BIT_AW +: WORD_AW];

  assign req_bit   = req_r.block_index[BIT_AW-1:0];
  assign bit_mask  = WORD_BITS'(1) << req_bit;
  assign inv_word  = ~mem_rdata;
  assign scan_next_w = LIMW_W'(scan_r) + LIMW_W'(1);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    scan_nxt      = scan_r;
    clr_nxt       = clr_r;
    hit_nxt       = hit_r;
    sectors_nxt   = sectors_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_raddr     = scan_r;

    if (cfg_wr_en) begin
      sectors_nxt = cfg_wr_data;
    end

    // output register drains on transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + WORD_AW'(1);
        if (clr_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          case (in_data.kind)
            KIND_TEST, KIND_USE, KIND_FREE: begin
              if (blk_ok) begin
                mem_raddr = in_word;
                state_nxt = ST_RD;
              end else begin
                res_nxt.status = STAT_IGNORE;
                state_nxt      = ST_RESP;
              end
            end
            KIND_FIND: begin
              if (lim_words == '0) begin
                state_nxt = ST_RESP;
              end else begin
                mem_raddr = '0;
                scan_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            KIND_LOAD: begin
              if (widx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = in_data.word_index[WORD_AW-1:0];
                mem_wdata = in_data.load_data[WORD_BITS-1:0];
              end else begin
                res_nxt.status = STAT_IGNORE;
              end
              state_nxt = ST_RESP;
            end
            default: begin
              res_nxt.status = STAT_IGNORE;
              state_nxt      = ST_RESP;
            end
          endcase
        end
      end

      ST_RD: begin
        mem_waddr = req_r.block_index[BIT_AW +: WORD_AW];
        case (req_r.kind)
          KIND_TEST: begin
            res_nxt.is_free = ~mem_rdata[req_bit];
          end
          KIND_USE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | bit_mask;
          end
          KIND_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~bit_mask;
          end
          default: begin
          end
        endcase
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        if (inv_word != '0) begin
          hit_nxt   = inv_word;
          state_nxt = ST_ENC;
        end else if (scan_next_w == lim_words) begin
          state_nxt = ST_RESP;          // full map: found stays 0
        end else begin
          scan_nxt  = scan_next_w[WORD_AW-1:0];
          mem_raddr = scan_next_w[WORD_AW-1:0];
        end
      end

      ST_ENC: begin
        res_nxt.found      = 1'b1;
        res_nxt.free_block = BLK_W'({scan_r, lowest_set(hit_r)});
        state_nxt          = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      sectors_r   <= SECTORS_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      sectors_r   <= sectors_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    scan_r     <= scan_nxt;
    hit_r      <= hit_nxt;
  end

endmodule
`default_nettype wire

### hdl/bbm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
